[rtl/free_list_handle_allocator_macros.svh]
// Assertion macros for the free-list handle allocator.
`ifndef FREE_LIST_HANDLE_ALLOCATOR_MACROS_SVH
`define FREE_LIST_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
// Checked property, held off while reset is high
`define FHA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("free list allocator check failed");
// Checked property, also checked during reset
`define FHA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("free list allocator check failed");
`else
`define FHA_ASSERT(name, clk, rst, prop)
`define FHA_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/fhalloc_pkg.sv]
`default_nettype none

package fhalloc_pkg;

  // Fixed field widths
  localparam int SLOT_BITS   = 10;
  localparam int HANDLE_BITS = 32;
  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 2;

  // Request modes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_INSERT     = 3'd0,
    MODE_REMOVE     = 3'd1,
    MODE_ORD_REMOVE = 3'd2,
    MODE_REPLACE    = 3'd3,
    MODE_RESET      = 3'd4
  } mode_e;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_GROW,
    ST_POP_RD,
    ST_POP,
    ST_CHK,
    ST_WALK,
    ST_SPLICE,
    ST_RESP
  } state_e;

  // Request item
  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [SLOT_BITS-1:0]   slot_index;
    logic [HANDLE_BITS-1:0] handle_in;
  } req_t;

  // Result item
  typedef struct packed {
    logic [SLOT_BITS-1:0]   slot_out;
    logic [HANDLE_BITS-1:0] handle_out;
    logic [STATUS_BITS-1:0] status;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic grow_step;
    logic link_rd_head;
    logic link_rd_next;
    logic hmem_rd;
    logic pop;
    logic set_full;
    logic set_invalid;
    logic replace;
    logic free_slot;
    logic push_head;
    logic splice_a;
    logic splice_b;
    logic reset_all;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic head_empty;
    logic cg_full;
    logic grow_last;
    logic slot_ok;
    logic head_first;
    logic walk_go;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[rtl/fhalloc_ctrl.sv]
`default_nettype none

module fhalloc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire fhalloc_pkg::stat_t stat,
  output fhalloc_pkg::cmd_t       cmd
);

  fhalloc_pkg::state_e state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fhalloc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != fhalloc_pkg::ST_IDLE);
    case (state)
      fhalloc_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = fhalloc_pkg::ST_DISPATCH;
        end
      end
      fhalloc_pkg::ST_DISPATCH: begin
        case (stat.mode)
          fhalloc_pkg::MODE_INSERT: begin
            if (!stat.head_empty) begin
              cmd.link_rd_head = 1'b1;
              state_next       = fhalloc_pkg::ST_POP;
            end else if (stat.cg_full) begin
              cmd.set_full = 1'b1;
              state_next   = fhalloc_pkg::ST_RESP;
            end else begin
              state_next = fhalloc_pkg::ST_GROW;
            end
          end
          fhalloc_pkg::MODE_REMOVE, fhalloc_pkg::MODE_ORD_REMOVE,
          fhalloc_pkg::MODE_REPLACE: begin
            cmd.hmem_rd = 1'b1;
            state_next  = fhalloc_pkg::ST_CHK;
          end
          fhalloc_pkg::MODE_RESET: begin
            cmd.reset_all = 1'b1;
            state_next    = fhalloc_pkg::ST_RESP;
          end
          default: begin
            // unused modes answer with the defaults
            state_next = fhalloc_pkg::ST_RESP;
          end
        endcase
      end
      fhalloc_pkg::ST_GROW: begin
        cmd.grow_step = 1'b1;
        if (stat.grow_last) begin
          state_next = fhalloc_pkg::ST_POP_RD;
        end
      end
      fhalloc_pkg::ST_POP_RD: begin
        cmd.link_rd_head = 1'b1;
        state_next       = fhalloc_pkg::ST_POP;
      end
      fhalloc_pkg::ST_POP: begin
        cmd.pop    = 1'b1;
        state_next = fhalloc_pkg::ST_RESP;
      end
      fhalloc_pkg::ST_CHK: begin
        if (!stat.slot_ok) begin
          cmd.set_invalid = 1'b1;
          state_next      = fhalloc_pkg::ST_RESP;
        end else if (stat.mode == fhalloc_pkg::MODE_REPLACE) begin
          cmd.replace = 1'b1;
          state_next  = fhalloc_pkg::ST_RESP;
        end else begin
          cmd.free_slot = 1'b1;
          if (stat.mode == fhalloc_pkg::MODE_REMOVE || stat.head_first) begin
            cmd.push_head = 1'b1;
            state_next    = fhalloc_pkg::ST_RESP;
          end else begin
            cmd.link_rd_head = 1'b1;
            state_next       = fhalloc_pkg::ST_WALK;
          end
        end
      end
      fhalloc_pkg::ST_WALK: begin
        if (stat.walk_go) begin
          cmd.link_rd_next = 1'b1;
        end else begin
          cmd.splice_a = 1'b1;
          state_next   = fhalloc_pkg::ST_SPLICE;
        end
      end
      fhalloc_pkg::ST_SPLICE: begin
        cmd.splice_b = 1'b1;
        state_next   = fhalloc_pkg::ST_RESP;
      end
      fhalloc_pkg::ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = fhalloc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fhalloc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/fhalloc_dp.sv]
`default_nettype none

module fhalloc_dp #(
  parameter int ENTRY_BITS   = 6,
  parameter int MAX_CHUNKS   = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fhalloc_pkg::req_t  req,
  input  wire logic               rsp_stall,
  output logic                    rsp_valid,
  output fhalloc_pkg::rsp_t       rsp,
  input  wire fhalloc_pkg::cmd_t  cmd,
  output fhalloc_pkg::stat_t      stat
);

  localparam int SB          = fhalloc_pkg::SLOT_BITS;
  localparam int HB          = fhalloc_pkg::HANDLE_BITS;
  localparam int DEPTH       = 1 << SB;
  localparam int BW          = SB + 1;
  localparam int CHUNK_CAP   = DEPTH >> ENTRY_BITS;
  localparam int CHUNK_LIMIT = (MAX_CHUNKS < CHUNK_CAP) ? MAX_CHUNKS : CHUNK_CAP;
  localparam int CG_W        = $clog2(CHUNK_LIMIT + 1);
  // stored handle bits: the item field carries at most HB of them
  localparam int HSW         = (HANDLE_WIDTH < HB) ? HANDLE_WIDTH : HB;

  // Memories: next-free links, and {in use, handle}
  logic [SB-1:0]  link_mem [DEPTH];
  logic [HSW:0]   hmem     [DEPTH];

  // Request and table registers
  logic [fhalloc_pkg::MODE_BITS-1:0] mode_r;
  logic [SB-1:0]   slot_r;
  logic [HSW-1:0]  handle_r;
  logic [SB-1:0]   free_head;
  logic [CG_W-1:0] chunks_grown;
  logic [ENTRY_BITS-1:0] grow_cnt;
  logic [SB-1:0]   walk_t;
  logic [SB-1:0]   link_rd;
  logic [HSW:0]    hrd;

  // Result registers
  logic [SB-1:0]   res_slot;
  logic [HB-1:0]   res_handle;
  fhalloc_pkg::status_e res_status;

  // Derived values
  logic [SB-1:0] grow_base;
  logic [SB-1:0] grow_addr;
  logic [SB-1:0] grow_link;
  logic [BW-1:0] bound;
  logic          grow_last;

  assign grow_base = SB'(chunks_grown) << ENTRY_BITS;
  assign grow_addr = grow_base | SB'(grow_cnt);
  assign grow_last = (grow_cnt == '1);
  assign grow_link = grow_last ? free_head : grow_addr + SB'(1);
  assign bound     = BW'(chunks_grown) << ENTRY_BITS;

  // Status towards the controller
  always_comb begin
    stat            = '0;
    stat.mode       = mode_r;
    stat.head_empty = (free_head == '0);
    stat.cg_full    = (chunks_grown >= CG_W'(CHUNK_LIMIT));
    stat.grow_last  = grow_last;
    stat.slot_ok    = (slot_r != '0) && ({1'b0, slot_r} < bound) && hrd[HSW];
    stat.head_first = (free_head == '0) || (slot_r < free_head);
    stat.walk_go    = (link_rd != '0) && (link_rd < slot_r);
    stat.out_free   = !rsp_valid || !rsp_stall;
  end

  // Link memory port select
  logic          link_we;
  logic [SB-1:0] link_waddr;
  logic [SB-1:0] link_wdata;
  logic          link_re;
  logic [SB-1:0] link_raddr;

  always_comb begin
    link_we    = 1'b1;
    link_waddr = slot_r;
    link_wdata = free_head;
    if (cmd.grow_step) begin
      link_waddr = grow_addr;
      link_wdata = grow_link;
    end else if (cmd.push_head) begin
      link_waddr = slot_r;
      link_wdata = free_head;
    end else if (cmd.splice_a) begin
      link_waddr = slot_r;
      link_wdata = link_rd;
    end else if (cmd.splice_b) begin
      link_waddr = walk_t;
      link_wdata = slot_r;
    end else begin
      link_we = 1'b0;
    end
    link_re    = cmd.link_rd_head || cmd.link_rd_next;
    link_raddr = cmd.link_rd_next ? link_rd : free_head;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd <= link_mem[link_raddr];
    end
  end

  // Handle memory port select
  logic          hmem_we;
  logic [SB-1:0] hmem_waddr;
  logic [HSW:0]  hmem_wdata;

  always_comb begin
    hmem_we    = 1'b1;
    hmem_waddr = slot_r;
    hmem_wdata = '0;
    if (cmd.grow_step) begin
      hmem_waddr = grow_addr;
    end else if (cmd.pop) begin
      hmem_waddr = free_head;
      hmem_wdata = {1'b1, handle_r};
    end else if (cmd.replace) begin
      hmem_wdata = {1'b1, handle_r};
    end else if (!cmd.free_slot) begin
      hmem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hmem_we) begin
      hmem[hmem_waddr] <= hmem_wdata;
    end
    if (cmd.hmem_rd) begin
      hrd <= hmem[slot_r];
    end
  end

  // Request capture, walk pointer and results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= req.mode;
      slot_r     <= req.slot_index;
      handle_r   <= req.handle_in[HSW-1:0];
      res_slot   <= req.slot_index;
      res_handle <= '0;
      res_status <= fhalloc_pkg::STATUS_OK;
    end
    if (cmd.link_rd_head) begin
      walk_t <= free_head;
    end else if (cmd.link_rd_next) begin
      walk_t <= link_rd;
    end
    if (cmd.pop) begin
      res_slot <= free_head;
    end
    if (cmd.set_full) begin
      res_slot   <= '0;
      res_status <= fhalloc_pkg::STATUS_FULL;
    end
    if (cmd.set_invalid) begin
      res_status <= fhalloc_pkg::STATUS_INVALID;
    end
    if (cmd.free_slot) begin
      res_handle <= HB'(hrd[HSW-1:0]);
    end
  end

  // Free-list head, chunk count and growth counter
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head    <= '0;
      chunks_grown <= '0;
      grow_cnt     <= '0;
    end else begin
      if (cmd.grow_step) begin
        grow_cnt <= grow_cnt + ENTRY_BITS'(1);
        if (grow_last) begin
          // slot 0 stays reserved
          free_head    <= (grow_base == '0) ? SB'(1) : grow_base;
          chunks_grown <= chunks_grown + CG_W'(1);
        end
      end
      if (cmd.pop) begin
        free_head <= link_rd;
      end
      if (cmd.push_head) begin
        free_head <= slot_r;
      end
      if (cmd.reset_all) begin
        free_head    <= '0;
        chunks_grown <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.slot_out   <= res_slot;
      rsp.handle_out <= res_handle;
      rsp.status     <= res_status;
    end
  end

endmodule

`default_nettype wire

[rtl/free_list_handle_allocator.sv]
// Free-list handle allocator: hands out slot numbers 1..1023 for stored item handles, growing
// the table one chunk of 2^ENTRY_BITS slots at a time up to min(MAX_CHUNKS, 1024 >> ENTRY_BITS)
// chunks; slot 0 is never given out. One request is worked at a time and one result item
// comes back for each. An insert pops the free-list head; when the free list is empty it first
// grows a chunk (one slot written per cycle), or answers full when no chunk is left to grow.
// Remove, replace and an invalid index read the slot's stored word and check it. An ordered
// remove puts the freed slot at the list head, or else walks down the ascending free list
// past each smaller free entry and splices it in. The link and handle memories have
// registered reads. A result held off by the receiver keeps the block in its answer state, so
// the next request waits for it. The memories need no clearing pass: a slot's stored word is
// only trusted once its chunk has been grown.
`default_nettype none

`include "free_list_handle_allocator_macros.svh"

module free_list_handle_allocator #(
  parameter int ENTRY_BITS   = 6,
  parameter int MAX_CHUNKS   = 16,
  parameter int HANDLE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire fhalloc_pkg::req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output fhalloc_pkg::rsp_t      rsp
);

  fhalloc_pkg::cmd_t  cmd;
  fhalloc_pkg::stat_t stat;

  // Sequencer
  fhalloc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Tables, list pointers and output register
  fhalloc_dp #(
    .ENTRY_BITS   (ENTRY_BITS),
    .MAX_CHUNKS   (MAX_CHUNKS),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

  // One item in flight: the cycle after an accept takes nothing
  `FHA_ASSERT(a_one_in_flight, clk, rst, (req_valid && !req_stall) |=> req_stall)
  // A full answer never names a slot
  `FHA_ASSERT(a_full_no_slot, clk, rst, (rsp_valid && rsp.status == fhalloc_pkg::STATUS_FULL) |-> (rsp.slot_out == '0))
  // Only a good remove hands a handle back
  `FHA_ASSERT(a_handle_only_ok, clk, rst, (rsp_valid && rsp.status != fhalloc_pkg::STATUS_OK) |-> (rsp.handle_out == '0))
  // Out of reset nothing is offered
  `FHA_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!rsp_valid && !req_stall))

endmodule

`default_nettype wire
